### hdl/svk_pkg.sv
package svk_pkg;

    localparam int unsigned W_WORD = 32;
    localparam int unsigned W_CFG_IDX = 1;
    localparam int unsigned W_TDATA_IN = 9 * W_WORD;
    // row_index(2) p(96) s(96) energy(32) -> 226, padded to 232
    localparam int unsigned W_TDATA_OUT = 232;

    localparam logic [W_CFG_IDX-1:0] CFG_LAMBDA = 1'b0;
    localparam logic [W_CFG_IDX-1:0] CFG_MU = 1'b1;

    typedef logic signed [W_WORD-1:0] t_word;

    typedef struct packed {
        logic [1:0] row_index;
        t_word      p_c0;
        t_word      p_c1;
        t_word      p_c2;
        t_word      s_c0;
        t_word      s_c1;
        t_word      s_c2;
        t_word      energy;
        logic       last_row;
    } t_row;

    // clamp a wide signed value to 32 bits
    function automatic t_word sat32(input logic signed [69:0] v);
        if (v > 70'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -70'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[W_WORD-1:0];
        end
    endfunction

endpackage

### hdl/svk_core.sv
// Pipelined arithmetic: F in, P rows, S rows and energy out after seven stages.
module svk_core #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  svk_pkg::t_word      i_f [9],
    input  svk_pkg::t_word      i_lambda,
    input  svk_pkg::t_word      i_mu,
    output logic                o_valid,
    output svk_pkg::t_word      o_p [9],
    output svk_pkg::t_word      o_s [9],
    output svk_pkg::t_word      o_w
);
    import svk_pkg::*;

    localparam int unsigned NST = 7;
    localparam int unsigned NF = 5;

    typedef logic signed [63:0] t_prod;
    typedef logic signed [69:0] t_acc;

    // round half up by s bits (s >= 1)
    function automatic t_acc rnd(input t_acc v, input int unsigned s);
        t_acc b;
        b = t_acc'(1) <<< (s - 1);
        return (v + b) >>> s;
    endfunction

    logic [NST-1:0] r_v;
    t_word r_f [NF][9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f[0] <= i_f;
            for (int s = 1; s < NF; s++) begin
                r_f[s] <= r_f[s-1];
            end
        end
    end

    // stage 1: products F_ki F_kj
    t_prod r_cp [9][3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_cp[i*3+j][k] <= t_prod'(i_f[k*3+i]) * t_prod'(i_f[k*3+j]);
                    end
                end
            end
        end
    end

    // stage 2: G
    t_word r_g [9];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    automatic t_acc c = '0;
                    for (int k = 0; k < 3; k++) begin
                        c = c + rnd(t_acc'(r_cp[i*3+j][k]), FRAC_BITS);
                    end
                    if (i == j) begin
                        c = c - (t_acc'(1) <<< FRAC_BITS);
                    end
                    r_g[i*3+j] <= sat32(rnd(c, 1));
                end
            end
        end
    end

    // stage 3: trace, mu G products, G G products
    t_word r_t;
    t_prod r_mg [9];
    t_prod r_gg [9];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= sat32(t_acc'(r_g[0]) + t_acc'(r_g[4]) + t_acc'(r_g[8]));
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_mg[i*3+j] <= t_prod'(i_mu) * t_prod'(r_g[i*3+j]);
                    r_gg[i*3+j] <= t_prod'(r_g[i*3+j]) * t_prod'(r_g[j*3+i]);
                end
            end
        end
    end

    // stage 4: lambda t, t t, sum G G
    t_prod r_lt;
    t_prod r_tt;
    t_word r_q;
    t_prod r_mg4 [9];
    always_ff @(posedge i_clk) begin
        automatic t_acc q = '0;
        if (i_en) begin
            r_lt <= t_prod'(i_lambda) * t_prod'(r_t);
            r_tt <= t_prod'(r_t) * t_prod'(r_t);
            for (int n = 0; n < 9; n++) begin
                q = q + rnd(t_acc'(r_gg[n]), FRAC_BITS);
            end
            r_q <= sat32(q);
            r_mg4 <= r_mg;
        end
    end

    // stage 5: S, t2, mu q
    t_word r_s [9];
    t_word r_t2;
    t_prod r_mq;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < 9; n++) begin
                r_s[n] <= sat32(((n % 4) == 0 ? rnd(t_acc'(r_lt), FRAC_BITS) : t_acc'(0))
                                + rnd(t_acc'(r_mg4[n]), FRAC_BITS - 1));
            end
            r_t2 <= sat32(rnd(t_acc'(r_tt), FRAC_BITS));
            r_mq <= t_prod'(i_mu) * t_prod'(r_q);
        end
    end

    // stage 6: F S products, lambda t2
    t_prod r_fs [9][3];
    t_prod r_lt2;
    t_prod r_mq6;
    t_word r_s6 [9];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_fs[i*3+j][k] <= t_prod'(r_f[4][i*3+k]) * t_prod'(r_s[k*3+j]);
                    end
                end
            end
            r_lt2 <= t_prod'(i_lambda) * t_prod'(r_t2);
            r_mq6 <= r_mq;
            r_s6 <= r_s;
        end
    end

    // stage 7: P and W
    t_word r_p [9];
    t_word r_w;
    t_word r_s7 [9];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < 9; n++) begin
                r_p[n] <= sat32(rnd(t_acc'(r_fs[n][0]), FRAC_BITS)
                              + rnd(t_acc'(r_fs[n][1]), FRAC_BITS)
                              + rnd(t_acc'(r_fs[n][2]), FRAC_BITS));
            end
            r_w <= sat32(rnd(t_acc'(r_lt2), FRAC_BITS + 1) + rnd(t_acc'(r_mq6), FRAC_BITS));
            r_s7 <= r_s6;
        end
    end

    // valid of stage 7
    assign o_valid = r_v[NST-1];
    assign o_p = r_p;
    assign o_s = r_s7;
    assign o_w = r_w;

endmodule

### hdl/svk_stress_update_unit.sv
// St Venant-Kirchhoff stress unit.
// s_axis: one word = one deformation gradient F (nine Q16.16 entries, row-major).
// m_axis: three words per F, rows 0,1,2 of P and S with the strain energy;
//         tlast marks row 2.
// cfg:    i_cfg_valid/o_cfg_ready, index 0 = lambda, 1 = mu; other indexes
//         are ignored. Write only while idle.
// F passes the seven pipe stages, then the serialiser; rows follow one per
// cycle while m_axis_tready is high. Throughput is set by the three row words
// on the single output channel; the pipe takes one a cycle while skid is free.
// Arithmetic: 7-stage pipe, at most one multiplier level per stage, then a 3-row
// serialiser holding one finished result, with a one-result skid buffer.
// Reset: clears valids and coefficients (both 0).
// Stall: when m_axis_tready is low the pipe freezes as a whole once the
// serialiser and skid are full; nothing is dropped or repeated.
module svk_stress_update_unit #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [svk_pkg::W_CFG_IDX-1:0]    i_cfg_index,
    input  logic [svk_pkg::W_WORD-1:0]       i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // f_11,f_12,f_13,f_21,f_22,f_23,f_31,f_32,f_33 from bit 0
    input  logic [svk_pkg::W_TDATA_IN-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // row_index[1:0], p_c0, p_c1, p_c2, s_c0, s_c1, s_c2, energy, zero pad
    output logic [svk_pkg::W_TDATA_OUT-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);
    import svk_pkg::*;

    t_word r_lambda, r_mu;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= '0;
            r_mu <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LAMBDA: r_lambda <= i_cfg_data;
                CFG_MU:     r_mu <= i_cfg_data;
                default:    ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    t_word f [9];
    always_comb begin
        for (int n = 0; n < 9; n++) begin
            f[n] = s_axis_tdata[n*W_WORD +: W_WORD];
        end
    end

    // result slots: serialiser slot and a skid slot
    logic   pipe_v;
    t_word  pipe_p [9];
    t_word  pipe_s [9];
    t_word  pipe_w;
    logic   en;

    t_word  r_sp [9];
    t_word  r_ss [9];
    t_word  r_sw;
    logic   r_sv;
    logic [1:0] r_row;
    t_word  r_kp [9];
    t_word  r_ks [9];
    t_word  r_kw;
    logic   r_kv;

    logic   done;
    assign done = r_sv && m_axis_tready && (r_row == 2'd2);

    // pipe advances while the skid slot is free
    assign en = !r_kv;
    assign s_axis_tready = en;

    svk_core #(.FRAC_BITS(FRAC_BITS)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid && s_axis_tready),
        .i_f      (f),
        .i_lambda (r_lambda),
        .i_mu     (r_mu),
        .o_valid  (pipe_v),
        .o_p      (pipe_p),
        .o_s      (pipe_s),
        .o_w      (pipe_w)
    );

    logic take_pipe;
    assign take_pipe = en && pipe_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_kv <= 1'b0;
            r_row <= '0;
        end else begin
            if (r_sv && m_axis_tready) begin
                r_row <= (r_row == 2'd2) ? 2'd0 : r_row + 2'd1;
            end
            if (!r_sv || done) begin
                if (r_kv) begin
                    r_sv <= 1'b1;
                    r_kv <= take_pipe;
                end else begin
                    r_sv <= take_pipe;
                end
            end else if (take_pipe) begin
                r_kv <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_sv || done) begin
            if (r_kv) begin
                r_sp <= r_kp; r_ss <= r_ks; r_sw <= r_kw;
            end else begin
                r_sp <= pipe_p; r_ss <= pipe_s; r_sw <= pipe_w;
            end
        end
        if (take_pipe && (r_kv || (r_sv && !done))) begin
            r_kp <= pipe_p; r_ks <= pipe_s; r_kw <= pipe_w;
        end
    end

    // first entry of the current row: 3 * row
    logic [3:0] row_base;
    assign row_base = {1'b0, r_row, 1'b0} + {2'b00, r_row};

    t_row row;
    always_comb begin
        row.row_index = r_row;
        row.p_c0 = r_sp[row_base];
        row.p_c1 = r_sp[row_base + 4'd1];
        row.p_c2 = r_sp[row_base + 4'd2];
        row.s_c0 = r_ss[row_base];
        row.s_c1 = r_ss[row_base + 4'd1];
        row.s_c2 = r_ss[row_base + 4'd2];
        row.energy = r_sw;
        row.last_row = (r_row == 2'd2);
    end

    assign m_axis_tvalid = r_sv;
    assign m_axis_tlast = row.last_row;
    assign m_axis_tdata = {6'd0, row.energy, row.s_c2, row.s_c1, row.s_c0,
                           row.p_c2, row.p_c1, row.p_c0, row.row_index};

`ifndef SYNTH
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row != 2'd3) else $error("row counter out of range");
    a_skid_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kv |-> r_sv) else $error("skid full with empty output slot");
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_row == 2'd0) else $error("row did not wrap");
`endif

endmodule
